>>> hdl/bcpe_pkg.sv
package bcpe_pkg;

   // fixed field widths
   localparam int unsigned IDX_W   = 6;
   localparam int unsigned COORD_W = 24;
   localparam int unsigned PARAM_W = 17;
   localparam int unsigned CSR_W   = 6;
   localparam int unsigned POW_W   = 33;   // Q0.32 with room for exactly 1.0
   localparam int unsigned COEF_W  = 34;   // capped weight, up to 2^33
   localparam int unsigned ACC_W   = 64;   // signed Q.48 sum

   localparam logic [PARAM_W-1:0] Q16_ONE  = 17'h1_0000;
   localparam logic [POW_W-1:0]   Q32_ONE  = 33'h1_0000_0000;
   localparam logic [COEF_W-1:0]  COEF_CAP = 34'h2_0000_0000;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_EVAL = 1'b1
   } opcode_type;

   typedef enum logic {
      CSR_FIRST_POINT = 1'b0,
      CSR_LAST_POINT  = 1'b1
   } csr_index_type;

   // sequencer to term pipeline
   typedef struct packed {
      logic issue;   // a term read was launched this cycle
      logic clear;   // zero the accumulators
   } term_ctl_type;

endpackage

>>> hdl/bezier_curve_point_eval_core.sv
// Channel  | Direction | Handshake              | Beat
// req_     | in        | req_valid / req_stall  | load point or evaluate at t
// rsp_     | out       | rsp_valid / rsp_stall  | curve point and span error
// csr_     | in        | csr_wr_en              | first_point / last_point write
//
// A load beat returns nothing. With n = last_point - first_point, an evaluate runs
// n + 1 power steps, n + 1 term reads, a drain of the four term stages and one round
// step, then returns to idle before the next beat is taken. Reversed or oversized
// spans skip straight to the round step. Reset is synchronous and clears
// control only; the point store holds garbage until loaded. A stalled result holds
// in the output register; a following evaluate waits in the round step until it is taken.
module bezier_curve_point_eval_core #(
   parameter int unsigned STORE_DEPTH = 64,
   parameter int unsigned MAX_SPAN    = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_opcode,
   input  logic [bcpe_pkg::IDX_W-1:0]           req_point_index,
   input  logic signed [bcpe_pkg::COORD_W-1:0] req_load_x,
   input  logic signed [bcpe_pkg::COORD_W-1:0] req_load_y,
   input  logic [bcpe_pkg::PARAM_W-1:0]         req_curve_param,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [bcpe_pkg::COORD_W-1:0] rsp_curve_x,
   output logic signed [bcpe_pkg::COORD_W-1:0] rsp_curve_y,
   output logic                                 rsp_span_error,

   input  logic                                 csr_wr_en,
   input  logic [0:0]                           csr_index,
   input  logic [bcpe_pkg::CSR_W-1:0]           csr_wdata
);

   localparam int unsigned SW = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
   localparam int unsigned BW = MAX_SPAN;   // C(n,i) <= 2^n, below 2^BW for n < MAX_SPAN
   localparam int unsigned PP_W = bcpe_pkg::POW_W + bcpe_pkg::PARAM_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POW,
      ST_TERM,
      ST_DRAIN,
      ST_FIN
   } state_type;

   state_type state_ff;

   // configuration
   logic [bcpe_pkg::IDX_W-1:0] first_ff, last_ff;

   // evaluation context
   logic [bcpe_pkg::PARAM_W-1:0] t_ff, u_ff;
   logic [bcpe_pkg::POW_W-1:0]   tp_ff, up_ff;
   logic [SW-1:0]                n_ff, k_ff, i_ff;
   logic                         err_ff;
   logic [BW-1:0]                row_ff [MAX_SPAN];
   logic [BW-1:0]                row_in [MAX_SPAN];

   // result register
   logic                                 rsp_valid_ff;
   logic signed [bcpe_pkg::COORD_W-1:0] rsp_x_ff, rsp_y_ff;
   logic                                 rsp_err_ff;

   // request decode
   logic                         req_take;
   logic                         take_load, take_eval;
   logic [bcpe_pkg::PARAM_W-1:0] t_clamp, u_val;
   logic [bcpe_pkg::IDX_W-1:0]   span;
   logic                         reversed, too_long;

   // power recurrence
   logic [PP_W-1:0]            tp_prod, up_prod;
   logic [bcpe_pkg::POW_W-1:0] tp_in, up_in;

   // term reads
   logic                              pow_wr;
   logic [SW-1:0]                     rd_u_addr;
   logic [bcpe_pkg::IDX_W-1:0]        pt_idx;
   logic [bcpe_pkg::POW_W-1:0]        t_pow, u_pow;
   logic signed [bcpe_pkg::COORD_W-1:0] pt_x, pt_y;
   logic                              term_issue;
   bcpe_pkg::term_ctl_type            term_ctl;
   logic                              pipe_busy;
   logic signed [bcpe_pkg::ACC_W-1:0] acc_x, acc_y;

   // finish
   logic                                 out_free;
   logic signed [bcpe_pkg::COORD_W-1:0] fin_x, fin_y;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign take_load = req_take && (req_opcode == bcpe_pkg::OP_LOAD);
   assign take_eval = req_take && (req_opcode == bcpe_pkg::OP_EVAL);

   assign t_clamp  = (req_curve_param > bcpe_pkg::Q16_ONE) ? bcpe_pkg::Q16_ONE
                                                           : req_curve_param;
   assign u_val    = bcpe_pkg::Q16_ONE - t_clamp;
   assign span     = last_ff - first_ff;
   assign reversed = last_ff < first_ff;
   assign too_long = 32'(span) >= MAX_SPAN;

   // p <- round(p * t / 2^16), Q0.32
   assign tp_prod = PP_W'(tp_ff) * PP_W'(t_ff);
   assign up_prod = PP_W'(up_ff) * PP_W'(u_ff);
   assign tp_in   = bcpe_pkg::POW_W'((tp_prod + PP_W'(32768)) >> 16);
   assign up_in   = bcpe_pkg::POW_W'((up_prod + PP_W'(32768)) >> 16);

   // next Pascal row, one per power step
   always_comb begin
      row_in[0] = row_ff[0];
      for (int j = 1; j < MAX_SPAN; j++) begin
         row_in[j] = row_ff[j] + row_ff[j-1];
      end
   end

   assign pow_wr     = (state_ff == ST_POW);
   assign term_issue = (state_ff == ST_TERM);
   assign rd_u_addr  = n_ff - i_ff;
   assign pt_idx     = bcpe_pkg::IDX_W'(7'(first_ff) + 7'(i_ff));

   assign term_ctl.issue = term_issue;
   assign term_ctl.clear = take_eval;

   bcpe_point_store #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (take_load),
      .wr_idx (req_point_index),
      .wr_x   (req_load_x),
      .wr_y   (req_load_y),
      .rd_en  (term_issue),
      .rd_idx (pt_idx),
      .rd_x   (pt_x),
      .rd_y   (pt_y)
   );

   bcpe_pow_ram #(
      .DEPTH (MAX_SPAN),
      .AW    (SW)
   ) u_tpow (
      .clock   (clock),
      .wr_en   (pow_wr),
      .wr_addr (k_ff),
      .wr_data (tp_ff),
      .rd_addr (i_ff),
      .rd_data (t_pow)
   );

   bcpe_pow_ram #(
      .DEPTH (MAX_SPAN),
      .AW    (SW)
   ) u_upow (
      .clock   (clock),
      .wr_en   (pow_wr),
      .wr_addr (k_ff),
      .wr_data (up_ff),
      .rd_addr (rd_u_addr),
      .rd_data (u_pow)
   );

   bcpe_term_pipe #(
      .BW (BW)
   ) u_pipe (
      .clock (clock),
      .reset (reset),
      .ctl   (term_ctl),
      .binom (row_ff[i_ff]),
      .t_pow (t_pow),
      .u_pow (u_pow),
      .pt_x  (pt_x),
      .pt_y  (pt_y),
      .busy  (pipe_busy),
      .acc_x (acc_x),
      .acc_y (acc_y)
   );

   // round half up from Q.48 to Q.16, then saturate
   function automatic logic signed [bcpe_pkg::COORD_W-1:0] finish_coord(
      input logic signed [bcpe_pkg::ACC_W-1:0] acc
   );
      logic signed [bcpe_pkg::ACC_W-1:0] biased;
      logic signed [31:0]                r;
      biased = acc + 64'sh8000_0000;
      r      = $signed(biased[63:32]);
      priority if (r > 32'sd8388607) begin
         finish_coord = 24'sh7F_FFFF;
      end else if (r < -32'sd8388608) begin
         finish_coord = -24'sh80_0000;
      end else begin
         finish_coord = r[bcpe_pkg::COORD_W-1:0];
      end
   endfunction

   assign fin_x    = finish_coord(acc_x);
   assign fin_y    = finish_coord(acc_y);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         first_ff     <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               bcpe_pkg::CSR_FIRST_POINT: first_ff <= csr_wdata;
               bcpe_pkg::CSR_LAST_POINT:  last_ff  <= csr_wdata;
               default: ;
            endcase
         end

         // load a fresh result from the round step, else drop the one taken
         if (state_ff == ST_FIN && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (take_eval) begin
                  t_ff   <= t_clamp;
                  u_ff   <= u_val;
                  tp_ff  <= bcpe_pkg::Q32_ONE;
                  up_ff  <= bcpe_pkg::Q32_ONE;
                  k_ff   <= '0;
                  i_ff   <= '0;
                  n_ff   <= SW'(span);
                  err_ff <= !reversed && too_long;
                  for (int j = 0; j < MAX_SPAN; j++) begin
                     row_ff[j] <= (j == 0) ? BW'(1) : '0;
                  end
                  // reversed or oversized spans skip straight to the result
                  state_ff <= (reversed || too_long) ? ST_FIN : ST_POW;
               end
            end
            ST_POW: begin
               // write power k this cycle, advance recurrence and row
               if (k_ff == n_ff) begin
                  state_ff <= ST_TERM;
               end else begin
                  k_ff  <= k_ff + SW'(1);
                  tp_ff <= tp_in;
                  up_ff <= up_in;
                  for (int j = 0; j < MAX_SPAN; j++) begin
                     row_ff[j] <= row_in[j];
                  end
               end
            end
            ST_TERM: begin
               if (i_ff == n_ff) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  i_ff <= i_ff + SW'(1);
               end
            end
            ST_DRAIN: begin
               if (!pipe_busy) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               // hold until the output register is free
               if (out_free) begin
                  rsp_x_ff     <= err_ff ? '0 : fin_x;
                  rsp_y_ff     <= err_ff ? '0 : fin_y;
                  rsp_err_ff   <= err_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_curve_x    = rsp_x_ff;
   assign rsp_curve_y    = rsp_y_ff;
   assign rsp_span_error = rsp_err_ff;

endmodule

>>> hdl/bcpe_point_store.sv
module bcpe_point_store #(
   parameter int unsigned STORE_DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [bcpe_pkg::IDX_W-1:0]           wr_idx,
   input  logic signed [bcpe_pkg::COORD_W-1:0] wr_x,
   input  logic signed [bcpe_pkg::COORD_W-1:0] wr_y,
   input  logic                                 rd_en,
   input  logic [bcpe_pkg::IDX_W-1:0]           rd_idx,
   output logic signed [bcpe_pkg::COORD_W-1:0] rd_x,
   output logic signed [bcpe_pkg::COORD_W-1:0] rd_y
);

   localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int unsigned DW = 2 * bcpe_pkg::COORD_W;

   logic [DW-1:0] mem [STORE_DEPTH];
   logic [DW-1:0] rd_data_ff;
   logic          rd_inside_ff;
   logic          wr_inside;
   logic          rd_inside;

   assign wr_inside = 32'(wr_idx) < STORE_DEPTH;
   assign rd_inside = 32'(rd_idx) < STORE_DEPTH;

   always_ff @(posedge clock) begin
      if (wr_en && wr_inside) begin
         mem[AW'(wr_idx)] <= {wr_x, wr_y};
      end
      if (rd_en) begin
         rd_data_ff   <= rd_inside ? mem[AW'(rd_idx)] : '0;
         rd_inside_ff <= rd_inside;
      end
   end

   // slots past the store read as the origin
   assign rd_x = rd_inside_ff ? $signed(rd_data_ff[DW-1:bcpe_pkg::COORD_W]) : '0;
   assign rd_y = rd_inside_ff ? $signed(rd_data_ff[bcpe_pkg::COORD_W-1:0]) : '0;

endmodule

>>> hdl/bcpe_pow_ram.sv
module bcpe_pow_ram #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = 4
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [bcpe_pkg::POW_W-1:0]    wr_data,
   input  logic [AW-1:0]                 rd_addr,
   output logic [bcpe_pkg::POW_W-1:0]    rd_data
);

   logic [bcpe_pkg::POW_W-1:0] mem [DEPTH];
   logic [bcpe_pkg::POW_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/bcpe_term_pipe.sv
module bcpe_term_pipe #(
   parameter int unsigned BW = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bcpe_pkg::term_ctl_type               ctl,
   input  logic [BW-1:0]                        binom,
   input  logic [bcpe_pkg::POW_W-1:0]           t_pow,
   input  logic [bcpe_pkg::POW_W-1:0]           u_pow,
   input  logic signed [bcpe_pkg::COORD_W-1:0] pt_x,
   input  logic signed [bcpe_pkg::COORD_W-1:0] pt_y,
   output logic                                 busy,
   output logic signed [bcpe_pkg::ACC_W-1:0]   acc_x,
   output logic signed [bcpe_pkg::ACC_W-1:0]   acc_y
);

   localparam int unsigned CP_W = BW + bcpe_pkg::POW_W;
   localparam int unsigned PR_W = bcpe_pkg::COEF_W + 1 + bcpe_pkg::COORD_W;

   // stage valids
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   // stage 1: memory outputs, binomial lines up with them
   logic [BW-1:0] binom_s1_ff;

   // stage 2: Bernstein weight
   logic [63:0]                        wprod;
   logic [63:0]                        wprod_rnd;
   logic [bcpe_pkg::POW_W-1:0]         w_in;
   logic [bcpe_pkg::POW_W-1:0]         w_ff;
   logic [BW-1:0]                      binom_s2_ff;
   logic signed [bcpe_pkg::COORD_W-1:0] px_s2_ff, py_s2_ff;

   // stage 3: capped coefficient
   logic [CP_W-1:0]                    cprod;
   logic [bcpe_pkg::COEF_W-1:0]        coef_in;
   logic [bcpe_pkg::COEF_W-1:0]        coef_ff;
   logic signed [bcpe_pkg::COORD_W-1:0] px_s3_ff, py_s3_ff;

   // stage 4: coefficient times point
   logic signed [PR_W-1:0] coef_s, px_ext, py_ext;
   logic signed [PR_W-1:0] prod_x_ff, prod_y_ff;

   logic signed [bcpe_pkg::ACC_W-1:0] acc_x_ff, acc_y_ff;

   assign wprod     = 64'(t_pow[31:0]) * 64'(u_pow[31:0]);
   assign wprod_rnd = wprod + 64'h8000_0000;

   // a factor of exactly 1.0 passes the other one through
   always_comb begin
      priority if (t_pow[bcpe_pkg::POW_W-1]) begin
         w_in = u_pow;
      end else if (u_pow[bcpe_pkg::POW_W-1]) begin
         w_in = t_pow;
      end else begin
         w_in = {1'b0, wprod_rnd[63:32]};
      end
   end

   assign cprod   = CP_W'(binom_s2_ff) * CP_W'(w_ff);
   assign coef_in = (cprod > CP_W'(bcpe_pkg::COEF_CAP)) ? bcpe_pkg::COEF_CAP
                                                        : bcpe_pkg::COEF_W'(cprod);

   assign coef_s = $signed({{(PR_W - bcpe_pkg::COEF_W){1'b0}}, coef_ff});
   assign px_ext = PR_W'(px_s3_ff);
   assign py_ext = PR_W'(py_s3_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= ctl.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end

      binom_s1_ff <= binom;

      w_ff        <= w_in;
      binom_s2_ff <= binom_s1_ff;
      px_s2_ff    <= pt_x;
      py_s2_ff    <= pt_y;

      coef_ff  <= coef_in;
      px_s3_ff <= px_s2_ff;
      py_s3_ff <= py_s2_ff;

      prod_x_ff <= coef_s * px_ext;
      prod_y_ff <= coef_s * py_ext;

      if (ctl.clear) begin
         acc_x_ff <= '0;
         acc_y_ff <= '0;
      end else if (v4_ff) begin
         acc_x_ff <= acc_x_ff + bcpe_pkg::ACC_W'(prod_x_ff);
         acc_y_ff <= acc_y_ff + bcpe_pkg::ACC_W'(prod_y_ff);
      end
   end

   assign busy  = v1_ff | v2_ff | v3_ff | v4_ff;
   assign acc_x = acc_x_ff;
   assign acc_y = acc_y_ff;

endmodule

>>> hdl/bcpe_checker.sv
module bcpe_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 req_opcode,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [bcpe_pkg::COORD_W-1:0] rsp_curve_x,
   input logic signed [bcpe_pkg::COORD_W-1:0] rsp_curve_y,
   input logic                                 rsp_span_error
);

   // a stalled result beat stays
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_curve_x)
         && $stable(rsp_curve_y) && $stable(rsp_span_error))
      else $error("result beat changed while stalled");

   // an oversized span carries the origin
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_span_error |-> rsp_curve_x == '0 && rsp_curve_y == '0)
      else $error("span error with nonzero point");

   // an evaluate beat stalls the request side on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_opcode == bcpe_pkg::OP_EVAL |=> req_stall)
      else $error("evaluate beat did not stall the request side");

   // a load beat never blocks the next one
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_opcode == bcpe_pkg::OP_LOAD |=> !req_stall)
      else $error("load beat stalled the request side");

endmodule

bind bezier_curve_point_eval_core bcpe_checker u_bcpe_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_opcode     (req_opcode),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_curve_x    (rsp_curve_x),
   .rsp_curve_y    (rsp_curve_y),
   .rsp_span_error (rsp_span_error)
);
